// ===== rtl/core/vna_pkg.sv =====
package vna_pkg;

    localparam int VERTICES_DEF   = 1024;
    localparam int COORD_BITS_DEF = 16;
    localparam int SUM_BITS_DEF   = 48;

    localparam int FIELD_IDX_W  = 10;
    localparam int FIELD_CRD_W  = 16;
    localparam int CFG_W        = 11;
    localparam int VCOUNT_RESET = 1024;

    localparam int MUL_W     = 32;
    localparam int RAD_W     = 64;
    localparam int ROOT_W    = 32;
    localparam int OUT_W     = 16;
    localparam int Q_FRAC    = OUT_W - 1;
    localparam int NORM_HI   = 30;
    localparam int DIV_STEPS = Q_FRAC + 2;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam int NUM_W     = NORM_HI + Q_FRAC + 1;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_FACE  = 2'd1,
        KIND_READ  = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

endpackage

// ===== rtl/core/vna_isqrt.sv =====
module vna_isqrt
    import vna_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic             run_reg;
    logic             done_reg;
    logic [RAD_W-1:0] rem_reg;
    logic [RAD_W-1:0] res_reg;
    logic [RAD_W-1:0] bit_reg;
    logic [RAD_W-1:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            rem_reg  <= '0;
            res_reg  <= '0;
            bit_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                rem_reg <= radicand;
                res_reg <= '0;
                bit_reg <= RAD_W'(1) << (RAD_W - 2);
            end
            else if (run_reg)
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg <= rem_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (bit_reg == RAD_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule

// ===== rtl/core/vertex_normal_accumulator_core.sv =====
// Vertex write: stores the position. Face add: three position reads, six products
// through the shared multiplier, three read-modify-writes of the sums.
// Normal read: a shift search, the 32-step root and three 17-step divisions; the
// result strobe is high for one cycle. Clear: the first min(vertex_count, VERTICES)
// sums are swept to zero. After reset all VERTICES sums are swept to zero with busy
// high. The receiver cannot stall a result.
module vertex_normal_accumulator_core
    import vna_pkg::*;
#(
    parameter int VERTICES   = VERTICES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int SUM_BITS   = SUM_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cfg_we,
    input  logic [CFG_W-1:0]              cfg_data,
    input  logic [1:0]                    kind,
    input  logic [FIELD_IDX_W-1:0]        vertex_index,
    input  logic signed [FIELD_CRD_W-1:0] coord_x,
    input  logic signed [FIELD_CRD_W-1:0] coord_y,
    input  logic signed [FIELD_CRD_W-1:0] coord_z,
    input  logic [FIELD_IDX_W-1:0]        corner_a,
    input  logic [FIELD_IDX_W-1:0]        corner_b,
    input  logic [FIELD_IDX_W-1:0]        corner_c,
    output logic                          out_valid,
    output logic [FIELD_IDX_W-1:0]        out_index,
    output logic signed [OUT_W-1:0]       normal_x,
    output logic signed [OUT_W-1:0]       normal_y,
    output logic signed [OUT_W-1:0]       normal_z,
    output logic                          zero_length
);

    localparam int AW    = $clog2(VERTICES);
    localparam int CW    = COORD_BITS;
    localparam int EW    = CW + 1;
    localparam int NW    = 2 * CW + 3;
    localparam int PW    = 3 * CW;
    localparam int SW    = SUM_BITS;
    localparam int ADD_W = ((SW > NW) ? SW : NW) + 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_PRD, S_EDGE, S_CROSS, S_SRD, S_SWT,
        S_NRD, S_NLD, S_NSH, S_SQ, S_ROOT, S_DINIT, S_DIV
    } state_t;

    state_t                   state_reg;
    logic [CFG_W-1:0]         vcount_reg;
    logic [AW-1:0]            clr_cnt_reg;
    logic [AW-1:0]            clr_last_reg;
    logic [2:0]               step_reg;
    logic [1:0]               comp_reg;
    logic [DCNT_W-1:0]        dcnt_reg;
    logic [AW-1:0]            corner_reg [3];
    logic [PW-1:0]            pos_reg [3];
    logic signed [EW-1:0]     e1_reg [3];
    logic signed [EW-1:0]     e2_reg [3];
    logic signed [2*MUL_W-1:0] prod_reg;
    logic signed [NW-1:0]     n_reg [3];
    logic [SW-1:0]            m_reg [3];
    logic                     neg_reg [3];
    logic [RAD_W-1:0]         q_reg;
    logic [ROOT_W-1:0]        len_reg;
    logic [DIV_STEPS-1:0]     num_reg;
    logic [ROOT_W:0]          rem_reg;
    logic [DIV_STEPS-1:0]     quot_reg;
    logic [OUT_W-1:0]         norm_reg [3];
    logic [FIELD_IDX_W-1:0]   idx_reg;
    logic                     out_valid_reg;
    logic [FIELD_IDX_W-1:0]   out_index_reg;
    logic [OUT_W-1:0]         out_n_reg [3];
    logic                     zero_reg;

    logic [PW-1:0]            pos_mem [VERTICES];
    logic [3*SW-1:0]          sum_mem [VERTICES];
    logic [PW-1:0]            pos_rd_reg;
    logic [3*SW-1:0]          sum_rd_reg;

    logic                     pos_we;
    logic [AW-1:0]            pos_waddr;
    logic [PW-1:0]            pos_wdata;
    logic [AW-1:0]            pos_raddr;
    logic                     sum_we;
    logic [AW-1:0]            sum_waddr;
    logic [3*SW-1:0]          sum_wdata;
    logic [AW-1:0]            sum_raddr;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic                     accept;
    logic                     idx_ok;
    logic                     face_ok;
    logic [SW-1:0]            mag [3];
    logic                     sgn [3];
    logic [SW-1:0]            or_m;
    logic [NUM_W-1:0]         num_init;
    logic [ROOT_W:0]          div_trial;
    logic                     div_bit;
    logic [DIV_STEPS-1:0]     quot_fin;
    logic                     root_start;
    logic [RAD_W-1:0]         radicand;
    logic                     root_done;
    logic [ROOT_W-1:0]        root;

    function automatic logic signed [CW-1:0] coord_of(logic [PW-1:0] p, int k);
        return signed'(p[k*CW +: CW]);
    endfunction

    function automatic logic [AW-1:0] corner_at(logic [2:0] s);
        case (s)
            3'd0:    return corner_reg[0];
            3'd1:    return corner_reg[1];
            default: return corner_reg[2];
        endcase
    endfunction

    function automatic logic signed [SW-1:0] sat_add(logic signed [SW-1:0] a,
                                                     logic signed [NW-1:0] b);
        logic signed [ADD_W-1:0] s;
        logic signed [SW-1:0]    hi;
        logic signed [SW-1:0]    lo;
        hi = {1'b0, {(SW-1){1'b1}}};
        lo = {1'b1, {(SW-1){1'b0}}};
        s  = ADD_W'(a) + ADD_W'(b);
        if (s > ADD_W'(hi))
            return hi;
        else if (s < ADD_W'(lo))
            return lo;
        else
            return SW'(s);
    endfunction

    function automatic logic [OUT_W-1:0] to_q15(logic [DIV_STEPS-1:0] q, logic neg);
        logic [DIV_STEPS-1:0] one;
        logic [DIV_STEPS-1:0] lim;
        one = DIV_STEPS'(1) << Q_FRAC;
        if (neg)
        begin
            lim = (q > one) ? one : q;
            lim = DIV_STEPS'(0) - lim;
            return lim[OUT_W-1:0];
        end
        else if (q >= one)
            return {1'b0, {(OUT_W-1){1'b1}}};
        else
            return q[OUT_W-1:0];
    endfunction

    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && !busy;
    assign idx_ok  = 32'(vertex_index) < VERTICES;
    assign face_ok = (32'(corner_a) < VERTICES) && (32'(corner_b) < VERTICES)
                     && (32'(corner_c) < VERTICES);

    assign pos_we    = accept && (kind == KIND_WRITE) && idx_ok;
    assign pos_waddr = AW'(vertex_index);
    assign pos_wdata = {CW'(coord_z), CW'(coord_y), CW'(coord_x)};
    assign pos_raddr = corner_at(step_reg);

    always_comb
    begin
        sum_we    = 1'b0;
        sum_waddr = corner_at(step_reg);
        sum_wdata = {sat_add(signed'(sum_rd_reg[2*SW +: SW]), n_reg[2]),
                     sat_add(signed'(sum_rd_reg[SW +: SW]), n_reg[1]),
                     sat_add(signed'(sum_rd_reg[0 +: SW]), n_reg[0])};
        sum_raddr = (state_reg == S_SRD) ? corner_at(step_reg) : AW'(idx_reg);
        if (state_reg == S_CLEAR)
        begin
            sum_we    = 1'b1;
            sum_waddr = clr_cnt_reg;
            sum_wdata = '0;
        end
        else if (state_reg == S_SWT)
        begin
            sum_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
            pos_mem[pos_waddr] <= pos_wdata;
        pos_rd_reg <= pos_mem[pos_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
            sum_mem[sum_waddr] <= sum_wdata;
        sum_rd_reg <= sum_mem[sum_raddr];
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_CROSS)
        begin
            case (step_reg)
                3'd0:
                begin
                    mul_a = MUL_W'(e1_reg[1]);
                    mul_b = MUL_W'(e2_reg[2]);
                end
                3'd1:
                begin
                    mul_a = MUL_W'(e1_reg[2]);
                    mul_b = MUL_W'(e2_reg[1]);
                end
                3'd2:
                begin
                    mul_a = MUL_W'(e1_reg[2]);
                    mul_b = MUL_W'(e2_reg[0]);
                end
                3'd3:
                begin
                    mul_a = MUL_W'(e1_reg[0]);
                    mul_b = MUL_W'(e2_reg[2]);
                end
                3'd4:
                begin
                    mul_a = MUL_W'(e1_reg[0]);
                    mul_b = MUL_W'(e2_reg[1]);
                end
                3'd5:
                begin
                    mul_a = MUL_W'(e1_reg[1]);
                    mul_b = MUL_W'(e2_reg[0]);
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
        else if (state_reg == S_SQ && step_reg < 3'd3)
        begin
            mul_a = signed'(MUL_W'(m_reg[step_reg[1:0]][NORM_HI-1:0]));
            mul_b = mul_a;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sgn[k] = sum_rd_reg[k*SW + SW - 1];
            mag[k] = sgn[k] ? (SW'(0) - sum_rd_reg[k*SW +: SW]) : sum_rd_reg[k*SW +: SW];
        end
    end

    assign or_m       = m_reg[0] | m_reg[1] | m_reg[2];
    assign num_init   = {m_reg[comp_reg][NORM_HI-1:0], {Q_FRAC{1'b0}}}
                        + NUM_W'(len_reg >> 1);
    assign div_trial  = {rem_reg[ROOT_W-1:0], num_reg[DIV_STEPS-1]};
    assign div_bit    = div_trial >= {1'b0, len_reg};
    assign quot_fin   = {quot_reg[DIV_STEPS-2:0], div_bit};
    assign root_start = (state_reg == S_SQ) && (step_reg == 3'd3);
    assign radicand   = q_reg + $unsigned(prod_reg);

    vna_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (radicand),
        .done     (root_done),
        .root     (root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            vcount_reg    <= CFG_W'(VCOUNT_RESET);
            clr_cnt_reg   <= '0;
            clr_last_reg  <= AW'(VERTICES - 1);
            step_reg      <= '0;
            comp_reg      <= '0;
            dcnt_reg      <= '0;
            prod_reg      <= '0;
            q_reg         <= '0;
            len_reg       <= '0;
            num_reg       <= '0;
            rem_reg       <= '0;
            quot_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_index_reg <= '0;
            zero_reg      <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                corner_reg[k] <= '0;
                pos_reg[k]    <= '0;
                e1_reg[k]     <= '0;
                e2_reg[k]     <= '0;
                n_reg[k]      <= '0;
                m_reg[k]      <= '0;
                neg_reg[k]    <= 1'b0;
                norm_reg[k]   <= '0;
                out_n_reg[k]  <= '0;
            end
        end
        else
        begin
            out_valid_reg <= 1'b0;
            prod_reg      <= mul_a * mul_b;
            if (cfg_we)
                vcount_reg <= cfg_data;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == clr_last_reg)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        idx_reg       <= vertex_index;
                        corner_reg[0] <= AW'(corner_a);
                        corner_reg[1] <= AW'(corner_b);
                        corner_reg[2] <= AW'(corner_c);
                        step_reg      <= '0;
                        case (kind_t'(kind))
                            KIND_FACE:
                            begin
                                if (face_ok)
                                    state_reg <= S_PRD;
                            end
                            KIND_READ:
                            begin
                                if (idx_ok)
                                    state_reg <= S_NRD;
                                else
                                begin
                                    out_valid_reg <= 1'b1;
                                    out_index_reg <= vertex_index;
                                    zero_reg      <= 1'b1;
                                    for (int k = 0; k < 3; k++)
                                        out_n_reg[k] <= '0;
                                end
                            end
                            KIND_CLEAR:
                            begin
                                clr_cnt_reg <= '0;
                                if (32'(vcount_reg) >= VERTICES)
                                    clr_last_reg <= AW'(VERTICES - 1);
                                else
                                    clr_last_reg <= AW'(32'(vcount_reg) - 32'd1);
                                if (vcount_reg != '0)
                                    state_reg <= S_CLEAR;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_PRD:
                begin
                    if (step_reg != 3'd0)
                        pos_reg[step_reg[1:0] - 2'd1] <= pos_rd_reg;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 3'd3)
                        state_reg <= S_EDGE;
                end
                S_EDGE:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        e1_reg[k] <= EW'(coord_of(pos_reg[1], k)) - EW'(coord_of(pos_reg[0], k));
                        e2_reg[k] <= EW'(coord_of(pos_reg[2], k)) - EW'(coord_of(pos_reg[0], k));
                    end
                    step_reg  <= '0;
                    state_reg <= S_CROSS;
                end
                S_CROSS:
                begin
                    if (step_reg != 3'd0)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            if ((step_reg - 3'd1) >> 1 == 3'(k))
                            begin
                                if (step_reg[0])
                                    n_reg[k] <= NW'(prod_reg);
                                else
                                    n_reg[k] <= n_reg[k] - NW'(prod_reg);
                            end
                        end
                    end
                    if (step_reg == 3'd6)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_SRD;
                    end
                    else
                        step_reg <= step_reg + 1'b1;
                end
                S_SRD:
                begin
                    state_reg <= S_SWT;
                end
                S_SWT:
                begin
                    if (step_reg == 3'd2)
                        state_reg <= S_IDLE;
                    else
                    begin
                        step_reg  <= step_reg + 1'b1;
                        state_reg <= S_SRD;
                    end
                end
                S_NRD:
                begin
                    state_reg <= S_NLD;
                end
                S_NLD:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        m_reg[k]   <= mag[k];
                        neg_reg[k] <= sgn[k];
                    end
                    if ((mag[0] | mag[1] | mag[2]) == '0)
                    begin
                        out_valid_reg <= 1'b1;
                        out_index_reg <= idx_reg;
                        zero_reg      <= 1'b1;
                        for (int k = 0; k < 3; k++)
                            out_n_reg[k] <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                        state_reg <= S_NSH;
                end
                S_NSH:
                begin
                    if (|or_m[SW-1:NORM_HI])
                    begin
                        for (int k = 0; k < 3; k++)
                            m_reg[k] <= m_reg[k] >> 1;
                    end
                    else if (!or_m[NORM_HI-1])
                    begin
                        for (int k = 0; k < 3; k++)
                            m_reg[k] <= m_reg[k] << 1;
                    end
                    else
                    begin
                        step_reg  <= '0;
                        q_reg     <= '0;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    if (step_reg != 3'd0)
                        q_reg <= radicand;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 3'd3)
                        state_reg <= S_ROOT;
                end
                S_ROOT:
                begin
                    if (root_done)
                    begin
                        len_reg   <= root;
                        comp_reg  <= '0;
                        state_reg <= S_DINIT;
                    end
                end
                S_DINIT:
                begin
                    rem_reg   <= (ROOT_W + 1)'(num_init >> DIV_STEPS);
                    num_reg   <= num_init[DIV_STEPS-1:0];
                    quot_reg  <= '0;
                    dcnt_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg  <= div_bit ? (div_trial - {1'b0, len_reg}) : div_trial;
                    quot_reg <= quot_fin;
                    num_reg  <= num_reg << 1;
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == DCNT_W'(DIV_STEPS - 1))
                    begin
                        norm_reg[comp_reg] <= to_q15(quot_fin, neg_reg[comp_reg]);
                        if (comp_reg == 2'd2)
                        begin
                            out_valid_reg <= 1'b1;
                            out_index_reg <= idx_reg;
                            zero_reg      <= 1'b0;
                            out_n_reg[0]  <= norm_reg[0];
                            out_n_reg[1]  <= norm_reg[1];
                            out_n_reg[2]  <= to_q15(quot_fin, neg_reg[2]);
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            comp_reg  <= comp_reg + 1'b1;
                            state_reg <= S_DINIT;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_index   = out_index_reg;
    assign normal_x    = signed'(out_n_reg[0]);
    assign normal_y    = signed'(out_n_reg[1]);
    assign normal_z    = signed'(out_n_reg[2]);
    assign zero_length = zero_reg;

    a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !busy)
        else $error("result shown while the block is busy");

    a_zero_flag_values: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_length) |-> (normal_x == '0 && normal_y == '0 && normal_z == '0))
        else $error("zero-length result carries a non-zero normal");

    a_unit_not_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !zero_length) |-> !(normal_x == '0 && normal_y == '0 && normal_z == '0))
        else $error("normalised result is all zero");

    a_root_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        root_done |-> state_reg == S_ROOT)
        else $error("root unit finished outside the wait state");

endmodule
